[hw/rtl/lapp_pkg.sv]
package lapp_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int NREG   = 6;
  localparam int REG_AW = 3;

  localparam logic [REG_AW-1:0] REG_CAM_X = 3'd0;
  localparam logic [REG_AW-1:0] REG_CAM_Y = 3'd1;
  localparam logic [REG_AW-1:0] REG_CAM_Z = 3'd2;
  localparam logic [REG_AW-1:0] REG_AIM_X = 3'd3;
  localparam logic [REG_AW-1:0] REG_AIM_Y = 3'd4;
  localparam logic [REG_AW-1:0] REG_AIM_Z = 3'd5;

  // look direction is scaled below 2^SCALE_BITS before the square roots
  localparam int SCALE_BITS = 30;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_VERT  = 2'd1,
    STAT_DZERO = 2'd2
  } stat_e;

  typedef struct packed {
    logic vert;
    logic dzero;
    logic behind;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } flags_t;

endpackage

[hw/rtl/lapp_coef.sv]
module lapp_coef #(
  parameter int COORD_BITS = lapp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = lapp_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [COORD_BITS-1:0]       cam_x_i,
  input  logic [COORD_BITS-1:0]       cam_y_i,
  input  logic [COORD_BITS-1:0]       cam_z_i,
  input  logic [COORD_BITS-1:0]       aim_x_i,
  input  logic [COORD_BITS-1:0]       aim_y_i,
  input  logic [COORD_BITS-1:0]       aim_z_i,
  output logic                        ready_o,
  output logic                        vert_o,
  output logic signed [FRAC_BITS+1:0] s1_o,
  output logic signed [FRAC_BITS+1:0] c1_o,
  output logic signed [FRAC_BITS+1:0] s2_o,
  output logic signed [FRAC_BITS+1:0] c2_o,
  output logic signed [FRAC_BITS+1:0] s1s2_o,
  output logic signed [FRAC_BITS+1:0] c1s2_o,
  output logic signed [FRAC_BITS+1:0] s1c2_o,
  output logic signed [FRAC_BITS+1:0] c1c2_o
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int TW   = F + 2;
  localparam int SB   = lapp_pkg::SCALE_BITS;
  localparam int KMAX = (C > SB) ? C - SB : 0;
  localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
  localparam int MW   = (C > SB) ? C : SB;
  localparam int SQW  = 2 * SB + 2;
  localparam int RTW  = 2 * SB + 4;
  localparam int RW   = SB + 1;
  localparam int NW   = RW + F;
  localparam int CW   = $clog2(NW + 1);

  typedef enum logic [2:0] {
    ST_DIFF, ST_SQ, ST_SUM, ST_ROOT1, ST_ROOT2, ST_DLOAD, ST_DIV, ST_PROD
  } state_e;

  state_e            state_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [1:0]        sel_q;
  logic [SB-1:0]     am_q [3];
  logic [2:0]        sgn_q;
  logic [2*SB-1:0]   sq_q [3];
  logic [SQW-1:0]    sum2_q;
  logic [RTW-1:0]    rv_q, rr_q, rb_q;
  logic [RW-1:0]     r1_q, r2_q;
  logic [RW-1:0]     drem_q, dden_q;
  logic [NW-1:0]     dq_q, dnum_q;
  logic              dneg_q;
  logic              vert_q;
  logic signed [TW-1:0] s1_q, c1_q, s2_q, c2_q, s1s2_q, c1s2_q, s1c2_q, c1c2_q;

  logic signed [C:0] dp [3];
  logic [MW-1:0]     dm [3];
  logic [MW-1:0]     mmax;
  logic [KW-1:0]     ksel;
  logic [SB-1:0]     am_d [3];
  logic [RTW-1:0]    rsum, rv_n, rr_n;
  logic              rge;
  logic [RW:0]       dtrial;
  logic              dge;
  logic [RW-1:0]     drem_n;
  logic [NW-1:0]     dq_n;
  logic signed [TW-1:0] tq;
  logic [RW-1:0]     num_sel, den_sel;
  logic              neg_sel;

  always_comb begin
    dp[0] = $signed({aim_x_i[C-1], aim_x_i}) - $signed({cam_x_i[C-1], cam_x_i});
    dp[1] = $signed({aim_y_i[C-1], aim_y_i}) - $signed({cam_y_i[C-1], cam_y_i});
    dp[2] = $signed({aim_z_i[C-1], aim_z_i}) - $signed({cam_z_i[C-1], cam_z_i});
    for (int i = 0; i < 3; i++) begin
      dm[i] = MW'(dp[i][C] ? C'(-dp[i]) : C'(dp[i]));
    end
    mmax = dm[0];
    if (dm[1] > mmax) mmax = dm[1];
    if (dm[2] > mmax) mmax = dm[2];
    ksel = KW'(KMAX);
    for (int j = KMAX; j >= 0; j--) begin
      if (((mmax >> j) >> SB) == '0) ksel = KW'(j);
    end
    for (int i = 0; i < 3; i++) begin
      am_d[i] = SB'(dm[i] >> ksel);
    end
  end

  always_comb begin
    rsum = rr_q + rb_q;
    rge  = rv_q >= rsum;
    rv_n = rge ? rv_q - rsum : rv_q;
    rr_n = rge ? (rr_q >> 1) + rb_q : (rr_q >> 1);
  end

  always_comb begin
    dtrial = {drem_q, dnum_q[NW-1]};
    dge    = dtrial >= {1'b0, dden_q};
    drem_n = dge ? RW'(dtrial - {1'b0, dden_q}) : RW'(dtrial);
    dq_n   = {dq_q[NW-2:0], dge};
    tq     = dneg_q ? -$signed({1'b0, dq_n[F:0]}) : $signed({1'b0, dq_n[F:0]});
  end

  always_comb begin
    case (sel_q)
      2'd0:    begin num_sel = RW'(am_q[0]); den_sel = r1_q; neg_sel = sgn_q[0]; end
      2'd1:    begin num_sel = RW'(am_q[1]); den_sel = r1_q; neg_sel = sgn_q[1]; end
      2'd2:    begin num_sel = RW'(am_q[2]); den_sel = r2_q; neg_sel = sgn_q[2]; end
      default: begin num_sel = r1_q;         den_sel = r2_q; neg_sel = 1'b0;     end
    endcase
  end

  function automatic logic signed [TW-1:0] tmul(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    return TW'(p >>> F);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DIFF;
      done_q  <= 1'b0;
      vert_q  <= 1'b0;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else if (restart_i) begin
      state_q <= ST_DIFF;
      done_q  <= 1'b0;
      vert_q  <= 1'b0;
    end else if (!done_q) begin
      case (state_q)
        ST_DIFF: begin
          vert_q <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            am_q[i]  <= am_d[i];
            sgn_q[i] <= dp[i][C];
          end
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          for (int i = 0; i < 3; i++) sq_q[i] <= am_q[i] * am_q[i];
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum2_q  <= SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
          rv_q    <= RTW'(SQW'(sq_q[0]) + SQW'(sq_q[1]));
          rr_q    <= '0;
          rb_q    <= RTW'(1) << (RTW - 2);
          cnt_q   <= '0;
          state_q <= ST_ROOT1;
        end
        ST_ROOT1, ST_ROOT2: begin
          rv_q  <= rv_n;
          rr_q  <= rr_n;
          rb_q  <= rb_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(RTW / 2 - 1)) begin
            cnt_q <= '0;
            rv_q  <= RTW'(sum2_q);
            rr_q  <= '0;
            rb_q  <= RTW'(1) << (RTW - 2);
            if (state_q == ST_ROOT1) begin
              r1_q <= RW'(rr_n);
              if (rr_n == '0) begin
                vert_q <= 1'b1;
                done_q <= 1'b1;
              end else begin
                state_q <= ST_ROOT2;
              end
            end else begin
              r2_q    <= RW'(rr_n);
              sel_q   <= '0;
              state_q <= ST_DLOAD;
            end
          end
        end
        ST_DLOAD: begin
          dnum_q  <= {num_sel, {F{1'b0}}};
          dden_q  <= den_sel;
          dneg_q  <= neg_sel;
          drem_q  <= '0;
          dq_q    <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          drem_q <= drem_n;
          dq_q   <= dq_n;
          dnum_q <= {dnum_q[NW-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CW'(NW - 1)) begin
            case (sel_q)
              2'd0:    s1_q <= tq;
              2'd1:    c1_q <= tq;
              2'd2:    s2_q <= tq;
              default: c2_q <= tq;
            endcase
            sel_q   <= sel_q + 1'b1;
            state_q <= (sel_q == 2'd3) ? ST_PROD : ST_DLOAD;
          end
        end
        ST_PROD: begin
          s1s2_q <= tmul(s1_q, s2_q);
          c1s2_q <= tmul(c1_q, s2_q);
          s1c2_q <= tmul(s1_q, c2_q);
          c1c2_q <= tmul(c1_q, c2_q);
          done_q <= 1'b1;
        end
        default: state_q <= ST_DIFF;
      endcase
    end
  end

  assign ready_o = done_q;
  assign vert_o  = vert_q;
  assign s1_o    = s1_q;
  assign c1_o    = c1_q;
  assign s2_o    = s2_q;
  assign c2_o    = c2_q;
  assign s1s2_o  = s1s2_q;
  assign c1s2_o  = c1s2_q;
  assign s1c2_o  = s1c2_q;
  assign c1c2_o  = c1c2_q;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> !ready_o) else $error("coefficients ready right after restart");
  a_vert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vert_q && !restart_i) |=> done_q) else $error("vertical look without done");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROD) |-> (sel_q == 2'd0)) else $error("division sequence out of step");

endmodule

[hw/rtl/lapp_front.sv]
module lapp_front #(
  parameter int COORD_BITS = lapp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = lapp_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [COORD_BITS-1:0]       px_i,
  input  logic [COORD_BITS-1:0]       py_i,
  input  logic [COORD_BITS-1:0]       pz_i,
  input  logic [COORD_BITS-1:0]       cam_x_i,
  input  logic [COORD_BITS-1:0]       cam_y_i,
  input  logic [COORD_BITS-1:0]       cam_z_i,
  input  logic                        vert_i,
  input  logic signed [FRAC_BITS+1:0] s1_i,
  input  logic signed [FRAC_BITS+1:0] c1_i,
  input  logic signed [FRAC_BITS+1:0] s2_i,
  input  logic signed [FRAC_BITS+1:0] c2_i,
  input  logic signed [FRAC_BITS+1:0] s1s2_i,
  input  logic signed [FRAC_BITS+1:0] c1s2_i,
  input  logic signed [FRAC_BITS+1:0] s1c2_i,
  input  logic signed [FRAC_BITS+1:0] c1c2_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [COORD_BITS+4:0]       ud_o,
  output logic [COORD_BITS+4:0]       unx_o,
  output logic [COORD_BITS+4:0]       uny_o,
  output logic [COORD_BITS+4:0]       remx_o,
  output logic [COORD_BITS+4:0]       remy_o,
  output lapp_pkg::flags_t            flags_o
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int TW = F + 2;
  localparam int VW = C + 1;
  localparam int PW = C + 3;
  localparam int SW = C + 5;

  function automatic logic signed [PW-1:0] mulq(input logic signed [TW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [TW+VW-1:0] p;
    p = a * b;
    return PW'(p >>> F);
  endfunction

  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  logic signed [VW-1:0] vx_q, vy_q, vz_q;
  logic signed [PW-1:0] xa_q, xb_q, ya_q, yb_q, yc_q, da_q, db_q, dc_q;
  logic signed [SW-1:0] x_q, y_q, d_q;
  logic [SW-1:0]        ud_q, unx_q, uny_q, remx_q, remy_q;
  lapp_pkg::flags_t     flags_q;

  logic [SW-1:0]   ux, uy, ud;
  logic [SW+F-1:0] nx, ny;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_comb begin
    ux = x_q[SW-1] ? SW'(-x_q) : SW'(x_q);
    uy = y_q[SW-1] ? SW'(-y_q) : SW'(y_q);
    ud = d_q[SW-1] ? SW'(-d_q) : SW'(d_q);
    nx = {ux, {F{1'b0}}} >> C;
    ny = {uy, {F{1'b0}}} >> C;
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      vx_q <= $signed({px_i[C-1], px_i}) - $signed({cam_x_i[C-1], cam_x_i});
      vy_q <= $signed({py_i[C-1], py_i}) - $signed({cam_y_i[C-1], cam_y_i});
      vz_q <= $signed({pz_i[C-1], pz_i}) - $signed({cam_z_i[C-1], cam_z_i});
    end
    if (rdy1) begin
      xa_q <= mulq(c1_i, vx_q);
      xb_q <= mulq(s1_i, vy_q);
      ya_q <= mulq(s1s2_i, vx_q);
      yb_q <= mulq(c1s2_i, vy_q);
      yc_q <= mulq(c2_i, vz_q);
      da_q <= mulq(s1c2_i, vx_q);
      db_q <= mulq(c1c2_i, vy_q);
      dc_q <= mulq(s2_i, vz_q);
    end
    if (rdy2) begin
      x_q <= SW'(xa_q) - SW'(xb_q);
      y_q <= SW'(yc_q) - SW'(ya_q) - SW'(yb_q);
      d_q <= SW'(da_q) + SW'(db_q) + SW'(dc_q);
    end
    if (rdy3) begin
      ud_q           <= ud;
      unx_q          <= ux;
      uny_q          <= uy;
      remx_q         <= SW'(nx);
      remy_q         <= SW'(ny);
      flags_q.vert   <= vert_i;
      flags_q.dzero  <= (d_q == '0);
      flags_q.behind <= d_q[SW-1];
      flags_q.neg_x  <= x_q[SW-1] ^ d_q[SW-1];
      flags_q.neg_y  <= (!y_q[SW-1] && (y_q != '0)) ^ d_q[SW-1];
      flags_q.ovf_x  <= nx >= (SW+F)'(ud);
      flags_q.ovf_y  <= ny >= (SW+F)'(ud);
    end
  end

  assign out_valid_o = v3_q;
  assign ud_o        = ud_q;
  assign unx_o       = unx_q;
  assign uny_o       = uny_q;
  assign remx_o      = remx_q;
  assign remy_o      = remy_q;
  assign flags_o     = flags_q;

endmodule

[hw/rtl/lapp_cell.sv]
module lapp_cell #(
  parameter int COORD_BITS = lapp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = lapp_pkg::FRAC_BITS,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS+4:0] ud_i,
  input  logic [COORD_BITS+4:0] unx_i,
  input  logic [COORD_BITS+4:0] uny_i,
  input  logic [COORD_BITS+4:0] remx_i,
  input  logic [COORD_BITS+4:0] remy_i,
  input  logic [COORD_BITS-1:0] qx_i,
  input  logic [COORD_BITS-1:0] qy_i,
  input  lapp_pkg::flags_t      flags_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS+4:0] ud_o,
  output logic [COORD_BITS+4:0] unx_o,
  output logic [COORD_BITS+4:0] uny_o,
  output logic [COORD_BITS+4:0] remx_o,
  output logic [COORD_BITS+4:0] remy_o,
  output logic [COORD_BITS-1:0] qx_o,
  output logic [COORD_BITS-1:0] qy_o,
  output lapp_pkg::flags_t      flags_o
);

  localparam int C  = COORD_BITS;
  localparam int SW = C + 5;

  logic nbx, nby;
  logic [SW:0]   tx, ty;
  logic          gx, gy;
  logic [C-1:0]  qx_n, qy_n;

  logic              valid_q;
  logic [SW-1:0]     ud_q, unx_q, uny_q, remx_q, remy_q;
  logic [C-1:0]      qx_q, qy_q;
  lapp_pkg::flags_t  flags_q;

  generate
    if (IDX >= FRAC_BITS) begin : g_num
      assign nbx = unx_i[IDX-FRAC_BITS];
      assign nby = uny_i[IDX-FRAC_BITS];
    end else begin : g_zero
      assign nbx = 1'b0;
      assign nby = 1'b0;
    end
  endgenerate

  always_comb begin
    tx   = {remx_i, nbx};
    ty   = {remy_i, nby};
    gx   = tx >= {1'b0, ud_i};
    gy   = ty >= {1'b0, ud_i};
    qx_n = qx_i;
    qy_n = qy_i;
    qx_n[IDX] = gx;
    qy_n[IDX] = gy;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      ud_q    <= ud_i;
      unx_q   <= unx_i;
      uny_q   <= uny_i;
      remx_q  <= gx ? SW'(tx - {1'b0, ud_i}) : SW'(tx);
      remy_q  <= gy ? SW'(ty - {1'b0, ud_i}) : SW'(ty);
      qx_q    <= qx_n;
      qy_q    <= qy_n;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ud_o        = ud_q;
  assign unx_o       = unx_q;
  assign uny_o       = uny_q;
  assign remx_o      = remx_q;
  assign remy_o      = remy_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;
  assign flags_o     = flags_q;

endmodule

[hw/rtl/look_at_point_projection.sv]
// A request passes the front-end registers, the divider cells and the output register.
// Throughput: one point per cycle (COORD_BITS-cell divider chain) unless the output stalls.
// After reset and after every config write the coefficient engine runs, stopping after the
// first square root for a vertical look; no request is taken while it runs.
// Reset: async active low; registers go to camera (0,0,0), target (0,1.0,0).
module look_at_point_projection #(
  parameter int COORD_BITS = lapp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = lapp_pkg::FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // screen_x, screen_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // status, behind
  output logic [2:0]                              m_axis_tuser,
  input  logic                                    cfg_we_i,
  input  logic [lapp_pkg::REG_AW-1:0]             cfg_addr_i,
  input  logic [COORD_BITS-1:0]                   cfg_wdata_i
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int SW  = C + 5;
  localparam int ODW = ((2 * C + 7) / 8) * 8;
  localparam logic [C-1:0] OneQ = C'(1 << F);
  localparam logic [C:0]   LimPos = (C+1)'(1) << (C - 1);

  logic [C-1:0] cam_x_q, cam_y_q, cam_z_q, aim_x_q, aim_y_q, aim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      aim_x_q <= '0;
      aim_y_q <= OneQ;
      aim_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lapp_pkg::REG_CAM_X: cam_x_q <= cfg_wdata_i;
        lapp_pkg::REG_CAM_Y: cam_y_q <= cfg_wdata_i;
        lapp_pkg::REG_CAM_Z: cam_z_q <= cfg_wdata_i;
        lapp_pkg::REG_AIM_X: aim_x_q <= cfg_wdata_i;
        lapp_pkg::REG_AIM_Y: aim_y_q <= cfg_wdata_i;
        lapp_pkg::REG_AIM_Z: aim_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic coef_rdy, vert;
  logic signed [TW-1:0] s1, c1, s2, c2, s1s2, c1s2, s1c2, c1c2;

  lapp_coef #(.COORD_BITS(C), .FRAC_BITS(F)) u_coef (
    .clk_i, .rst_ni,
    .restart_i (cfg_we_i),
    .cam_x_i (cam_x_q), .cam_y_i (cam_y_q), .cam_z_i (cam_z_q),
    .aim_x_i (aim_x_q), .aim_y_i (aim_y_q), .aim_z_i (aim_z_q),
    .ready_o (coef_rdy), .vert_o (vert),
    .s1_o (s1), .c1_o (c1), .s2_o (s2), .c2_o (c2),
    .s1s2_o (s1s2), .c1s2_o (c1s2), .s1c2_o (s1c2), .c1c2_o (c1c2)
  );

  logic             c_valid [0:C];
  logic             c_ready [0:C];
  logic [SW-1:0]    c_ud    [0:C];
  logic [SW-1:0]    c_unx   [0:C];
  logic [SW-1:0]    c_uny   [0:C];
  logic [SW-1:0]    c_remx  [0:C];
  logic [SW-1:0]    c_remy  [0:C];
  logic [C-1:0]     c_qx    [0:C];
  logic [C-1:0]     c_qy    [0:C];
  lapp_pkg::flags_t c_flags [0:C];

  logic fr_ready;

  assign s_axis_tready = fr_ready && coef_rdy;

  lapp_front #(.COORD_BITS(C), .FRAC_BITS(F)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid && coef_rdy),
    .in_ready_o  (fr_ready),
    .px_i (s_axis_tdata[C-1:0]),
    .py_i (s_axis_tdata[2*C-1:C]),
    .pz_i (s_axis_tdata[3*C-1:2*C]),
    .cam_x_i (cam_x_q), .cam_y_i (cam_y_q), .cam_z_i (cam_z_q),
    .vert_i (vert),
    .s1_i (s1), .c1_i (c1), .s2_i (s2), .c2_i (c2),
    .s1s2_i (s1s2), .c1s2_i (c1s2), .s1c2_i (s1c2), .c1c2_i (c1c2),
    .out_valid_o (c_valid[0]),
    .out_ready_i (c_ready[0]),
    .ud_o (c_ud[0]), .unx_o (c_unx[0]), .uny_o (c_uny[0]),
    .remx_o (c_remx[0]), .remy_o (c_remy[0]),
    .flags_o (c_flags[0])
  );

  assign c_qx[0] = '0;
  assign c_qy[0] = '0;

  for (genvar i = 0; i < C; i++) begin : g_cell
    lapp_cell #(.COORD_BITS(C), .FRAC_BITS(F), .IDX(C - 1 - i)) u_cell (
      .clk_i, .rst_ni,
      .in_valid_i (c_valid[i]), .in_ready_o (c_ready[i]),
      .ud_i (c_ud[i]), .unx_i (c_unx[i]), .uny_i (c_uny[i]),
      .remx_i (c_remx[i]), .remy_i (c_remy[i]),
      .qx_i (c_qx[i]), .qy_i (c_qy[i]), .flags_i (c_flags[i]),
      .out_valid_o (c_valid[i+1]), .out_ready_i (c_ready[i+1]),
      .ud_o (c_ud[i+1]), .unx_o (c_unx[i+1]), .uny_o (c_uny[i+1]),
      .remx_o (c_remx[i+1]), .remy_o (c_remy[i+1]),
      .qx_o (c_qx[i+1]), .qy_o (c_qy[i+1]), .flags_o (c_flags[i+1])
    );
  end

  logic             out_valid_q;
  logic [C-1:0]     sx_q, sy_q;
  lapp_pkg::stat_e  stat_q;
  logic             behind_q;

  logic [C:0]       qxx, qyy, limx, limy, qcx, qcy;
  logic [C-1:0]     sx_d, sy_d;
  lapp_pkg::stat_e  stat_d;
  logic             behind_d;
  lapp_pkg::flags_t fl;

  assign c_ready[C] = !out_valid_q || m_axis_tready;

  always_comb begin
    fl   = c_flags[C];
    qxx  = fl.ovf_x ? ((C+1)'(1) << C) : {1'b0, c_qx[C]};
    qyy  = fl.ovf_y ? ((C+1)'(1) << C) : {1'b0, c_qy[C]};
    limx = fl.neg_x ? LimPos : LimPos - 1'b1;
    limy = fl.neg_y ? LimPos : LimPos - 1'b1;
    qcx  = (qxx > limx) ? limx : qxx;
    qcy  = (qyy > limy) ? limy : qyy;
    if (fl.vert) begin
      sx_d = '0; sy_d = '0; stat_d = lapp_pkg::STAT_VERT; behind_d = 1'b0;
    end else if (fl.dzero) begin
      sx_d = '0; sy_d = '0; stat_d = lapp_pkg::STAT_DZERO; behind_d = 1'b0;
    end else begin
      sx_d     = fl.neg_x ? C'(-qcx) : C'(qcx);
      sy_d     = fl.neg_y ? C'(-qcy) : C'(qcy);
      stat_d   = lapp_pkg::STAT_OK;
      behind_d = fl.behind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_ready[C]) begin
      out_valid_q <= c_valid[C];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready[C]) begin
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      stat_q   <= stat_d;
      behind_q <= behind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({sy_q, sx_q});
  assign m_axis_tuser  = {behind_q, stat_q};

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready) else $error("input taken while coefficients rebuild");
  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q == lapp_pkg::STAT_VERT) |-> (sx_q == '0 && sy_q == '0 && !behind_q))
    else $error("vertical look with nonzero result");
  a_dzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q == lapp_pkg::STAT_DZERO) |-> (sx_q == '0 && sy_q == '0 && !behind_q))
    else $error("zero depth with nonzero result");
  a_behind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && behind_q) |-> (stat_q == lapp_pkg::STAT_OK))
    else $error("behind flag with error status");

endmodule
